// ===== hdl/salc_pkg.sv =====
// Shared types, codes and defaults for the set-associative LRU cache tracker.
package salc_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int STAMP_BITS_DEF   = 32;

    localparam int ADDR_W   = 64;
    localparam int COUNT_W  = 32;
    localparam int SHIFT_W  = 4;
    localparam int OPCODE_W = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STORE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MODIFY  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_INVALID = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_USED  = 2'd2;

    localparam logic [2:0] SET_BITS_RST   = 3'd4;
    localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
    localparam logic [3:0] WAYS_USED_RST  = 4'd1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ADDR_W-1:0]   address;
    } access_t;

    typedef struct packed {
        logic               was_hit;
        logic               was_miss;
        logic               was_eviction;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
        logic [COUNT_W-1:0] eviction_count;
    } result_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/salc_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
interface salc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== hdl/set_assoc_lru_cache_tracker.sv =====
// Top level of the set-associative LRU cache tracker.
//
// req carries one access per transaction (opcode, address); rsp returns one
// result per access: hit/miss/eviction flags and the running totals.
// cfg_we/cfg_index/cfg_data write set_bits (0), block_bits (1) and
// ways_used (2); other indexes are dropped. Write them only while idle.
// Each access is taken in the idle state, which reads its set row from the set
// RAM; the update state then compares all ways, picks the LRU victim and writes
// the row back, and the result is registered in the output register. req.ready
// is high only in idle, so a new access waits until the last one is updated.
// After reset the block sweeps the set RAM, one row per cycle, over all
// 2**MAX_SET_BITS rows (64 by default) with req.ready low; configuration
// writes are taken during the sweep. Counters and stamps reset to zero.
// A new access is taken while a result still waits on rsp; if rsp is
// stalled, the following access holds in its update cycle until the output
// register frees.
module set_assoc_lru_cache_tracker #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int STAMP_BITS   = salc_pkg::STAMP_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    salc_stream_if.sink                      req,
    salc_stream_if.source                    rsp,
    input  logic                             cfg_we,
    input  logic [salc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    salc_pkg::ctrl_cmd_t  cmd;
    salc_pkg::dp_status_t status;

    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    salc_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .STAMP_BITS   (STAMP_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_payload (req.payload),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_payload (rsp.payload),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

endmodule

// ===== hdl/salc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module salc_ram #(
    parameter int  WIDTH     = 8,
    parameter int  DEPTH     = 2,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/salc_ctrl.sv =====
// Controller state machine: clearing pass, access acceptance and set update.
module salc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  salc_pkg::dp_status_t  status,
    output salc_pkg::ctrl_cmd_t   cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/salc_datapath.sv =====
// Datapath: configuration, set memory, tag compare, LRU victim search and counters.
module salc_datapath #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int STAMP_BITS   = salc_pkg::STAMP_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  salc_pkg::ctrl_cmd_t                cmd,
    output salc_pkg::dp_status_t               status,
    input  salc_pkg::access_t                  req_payload,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output salc_pkg::result_t                  rsp_payload,
    input  logic                               cfg_we,
    input  logic [salc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_BITS = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int DEPTH     = 1 << MAX_SET_BITS;
    localparam int TAG_W     = salc_pkg::ADDR_W;
    localparam int LINE_W    = 1 + TAG_W + STAMP_BITS;
    localparam int ROW_W     = MAX_WAYS * LINE_W;
    localparam int WIDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int PAD       = 1 << $clog2(MAX_WAYS);
    localparam int WAYS_W    = $clog2(MAX_WAYS + 1);
    localparam int CW        = (WAYS_W > 4) ? WAYS_W : 4;
    localparam int CNT_W     = salc_pkg::COUNT_W;

    // configuration
    logic [2:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [3:0] ways_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= salc_pkg::SET_BITS_RST;
            block_bits_reg <= salc_pkg::BLOCK_BITS_RST;
            ways_used_reg  <= salc_pkg::WAYS_USED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                salc_pkg::CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                salc_pkg::CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                salc_pkg::CFG_WAYS_USED:  ways_used_reg  <= cfg_data[3:0];
                default:                  ;
            endcase
        end
    end

    // address split
    logic [salc_pkg::SHIFT_W-1:0] sb_eff;
    logic [TAG_W-1:0]             blk;
    logic [ADDR_BITS-1:0]         set_idx;
    logic [TAG_W-1:0]             tag_in;

    always_comb
    begin
        if ({1'b0, set_bits_reg} > salc_pkg::SHIFT_W'(MAX_SET_BITS))
        begin
            sb_eff = salc_pkg::SHIFT_W'(MAX_SET_BITS);
        end
        else
        begin
            sb_eff = {1'b0, set_bits_reg};
        end
        blk     = req_payload.address >> block_bits_reg;
        set_idx = blk[ADDR_BITS-1:0] & ~({ADDR_BITS{1'b1}} << sb_eff);
        tag_in  = blk >> sb_eff;
    end

    logic [ADDR_BITS-1:0]          set_reg;
    logic [TAG_W-1:0]              tag_reg;
    logic [salc_pkg::OPCODE_W-1:0] op_reg;
    logic [STAMP_BITS-1:0]         access_time_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_reg <= set_idx;
            tag_reg <= tag_in;
            op_reg  <= req_payload.opcode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_time_reg <= '0;
        end
        else if (cmd.accept)
        begin
            access_time_reg <= access_time_reg + STAMP_BITS'(1);
        end
    end

    // clearing pass
    logic [ADDR_BITS-1:0] clear_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clear_cnt_reg <= clear_cnt_reg + ADDR_BITS'(1);
        end
    end

    // set memory
    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     new_row;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [ROW_W-1:0]     wr_data;

    assign wr_en   = cmd.clear || (cmd.update && (op_reg != salc_pkg::OP_INVALID));
    assign wr_addr = cmd.clear ? clear_cnt_reg : set_reg;
    assign wr_data = cmd.clear ? '0 : new_row;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_set_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (set_idx),
        .rd_data (rd_row)
    );

    // way unpack
    logic [CW-1:0] ways_eff;

    always_comb
    begin
        if (ways_used_reg == 4'd0)
        begin
            ways_eff = CW'(1);
        end
        else if (CW'(ways_used_reg) > CW'(MAX_WAYS))
        begin
            ways_eff = CW'(MAX_WAYS);
        end
        else
        begin
            ways_eff = CW'(ways_used_reg);
        end
    end

    logic                  way_en    [PAD];
    logic                  way_valid [PAD];
    logic [TAG_W-1:0]      way_tag   [PAD];
    logic [STAMP_BITS-1:0] way_stamp [PAD];

    for (genvar g = 0; g < PAD; g++)
    begin : g_way
        if (g < MAX_WAYS)
        begin : g_used
            assign way_en[g]    = CW'(g) < ways_eff;
            assign way_valid[g] = rd_row[g*LINE_W + LINE_W - 1];
            assign way_tag[g]   = rd_row[g*LINE_W + STAMP_BITS +: TAG_W];
            assign way_stamp[g] = rd_row[g*LINE_W +: STAMP_BITS];
        end
        else
        begin : g_pad
            assign way_en[g]    = 1'b0;
            assign way_valid[g] = 1'b0;
            assign way_tag[g]   = '0;
            assign way_stamp[g] = '0;
        end
    end

    // lookup, fill and victim selection
    logic                  hit_found;
    logic [WIDX_W-1:0]     hit_idx;
    logic                  free_found;
    logic [WIDX_W-1:0]     free_idx;
    logic [STAMP_BITS-1:0] node_stamp [2*PAD];
    logic [WIDX_W-1:0]     node_idx   [2*PAD];
    logic                  node_ok    [2*PAD];
    logic [WIDX_W-1:0]     victim_idx;
    logic [WIDX_W-1:0]     way_sel;
    logic                  evict;
    logic [LINE_W-1:0]     new_line;

    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int w = PAD - 1; w >= 0; w--)
        begin
            if (way_en[w] && way_valid[w] && (way_tag[w] == tag_reg))
            begin
                hit_found = 1'b1;
                hit_idx   = WIDX_W'(w);
            end
            if (way_en[w] && !way_valid[w])
            begin
                free_found = 1'b1;
                free_idx   = WIDX_W'(w);
            end
        end
    end

    // oldest stamp, ties go to the higher way
    always_comb
    begin
        for (int i = 0; i < 2 * PAD; i++)
        begin
            node_stamp[i] = '0;
            node_idx[i]   = '0;
            node_ok[i]    = 1'b0;
        end
        for (int w = 0; w < PAD; w++)
        begin
            node_stamp[PAD + w] = way_stamp[w];
            node_idx[PAD + w]   = WIDX_W'(w);
            node_ok[PAD + w]    = way_en[w];
        end
        for (int i = PAD - 1; i >= 1; i--)
        begin
            if (node_ok[2*i + 1] &&
                (!node_ok[2*i] || (node_stamp[2*i + 1] <= node_stamp[2*i])))
            begin
                node_stamp[i] = node_stamp[2*i + 1];
                node_idx[i]   = node_idx[2*i + 1];
                node_ok[i]    = 1'b1;
            end
            else
            begin
                node_stamp[i] = node_stamp[2*i];
                node_idx[i]   = node_idx[2*i];
                node_ok[i]    = node_ok[2*i];
            end
        end
        victim_idx = node_idx[1];
    end

    always_comb
    begin
        evict    = !hit_found && !free_found;
        way_sel  = hit_found ? hit_idx : (free_found ? free_idx : victim_idx);
        new_line = {1'b1, tag_reg, access_time_reg};
        new_row  = rd_row;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WIDX_W'(w) == way_sel)
            begin
                new_row[w*LINE_W +: LINE_W] = new_line;
            end
        end
    end

    // counters and result
    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] misses_reg;
    logic [CNT_W-1:0] evictions_reg;
    logic [CNT_W-1:0] hits_next;
    logic [CNT_W-1:0] misses_next;
    logic [CNT_W-1:0] evictions_next;
    logic             lookup;
    logic             res_hit;
    logic             res_miss;
    logic             res_evict;

    always_comb
    begin
        lookup         = op_reg != salc_pkg::OP_INVALID;
        res_hit        = lookup && hit_found;
        res_miss       = lookup && !hit_found;
        res_evict      = lookup && evict;
        hits_next      = hits_reg + CNT_W'(res_hit)
                       + CNT_W'(op_reg == salc_pkg::OP_MODIFY);
        misses_next    = misses_reg + CNT_W'(res_miss);
        evictions_next = evictions_reg + CNT_W'(res_evict);
    end

    logic rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                evictions_reg <= evictions_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    salc_pkg::result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            result_reg.was_hit        <= res_hit;
            result_reg.was_miss       <= res_miss;
            result_reg.was_eviction   <= res_evict;
            result_reg.hit_count      <= hits_next;
            result_reg.miss_count     <= misses_next;
            result_reg.eviction_count <= evictions_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign rsp_payload = result_reg;

    assign status.clear_last = clear_cnt_reg == ADDR_BITS'(DEPTH - 1);
    assign status.out_free   = !rsp_valid_reg || rsp_ready;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the set-associative LRU cache tracker.
`timescale 1ns / 1ps

module testbench;
    import salc_pkg::*;

    localparam int LINE_COUNT    = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        STEP_ACCESS,
        STEP_CONFIG,
        STEP_DRAIN,
        STEP_MODE
    } step_kind_e;

    typedef struct packed {
        step_kind_e             kind;
        access_t                acc;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [6:0]             send_pct;
        logic [6:0]             recv_pct;
    } plan_step_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   acc_valid   = 1'b0;
    access_t                acc_payload = '0;
    logic                   res_ready   = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    salc_stream_if #(.payload_t(access_t)) req ();
    salc_stream_if #(.payload_t(result_t)) rsp ();

    assign req.valid   = acc_valid;
    assign req.payload = acc_payload;
    assign rsp.ready   = res_ready;

    set_assoc_lru_cache_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    plan_step_t access_plan[$];
    result_t    expected_results[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int quiet_cycles   = 0;
    int accepted_count = 0;
    int total_accesses = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    // cache image and settings as the hardware should hold them
    bit [ADDR_W-1:0]         way_tag   [LINE_COUNT];
    bit [STAMP_BITS_DEF-1:0] way_stamp [LINE_COUNT];
    bit                      way_valid [LINE_COUNT];
    bit [STAMP_BITS_DEF-1:0] stamp_now;
    bit [COUNT_W-1:0]        hits_seen;
    bit [COUNT_W-1:0]        misses_seen;
    bit [COUNT_W-1:0]        evictions_seen;
    logic [2:0]              cur_set_bits   = SET_BITS_RST;
    logic [5:0]              cur_block_bits = BLOCK_BITS_RST;
    logic [3:0]              cur_ways       = WAYS_USED_RST;

    // settings as the stimulus has queued them, for address shaping
    logic [2:0] plan_set_bits   = SET_BITS_RST;
    logic [5:0] plan_block_bits = BLOCK_BITS_RST;
    logic [3:0] plan_ways       = WAYS_USED_RST;

    function automatic result_t cache_lookup(access_t acc);
        result_t             res;
        int                  sb;
        int                  nways;
        int                  base;
        int                  victim;
        bit                  found;
        logic [ADDR_W-1:0]   blk;
        logic [ADDR_W-1:0]   set_sel;
        logic [ADDR_W-1:0]   tag;
        bit [STAMP_BITS_DEF-1:0] oldest;
        res = '0;
        stamp_now = stamp_now + 1'b1;
        if (acc.opcode != OP_INVALID) begin
            sb = (cur_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(cur_set_bits);
            nways = (cur_ways == 0) ? 1 : int'(cur_ways);
            if (nways > MAX_WAYS_DEF)
                nways = MAX_WAYS_DEF;
            blk     = acc.address >> cur_block_bits;
            set_sel = blk & ((64'd1 << sb) - 64'd1);
            tag     = blk >> sb;
            base    = int'(set_sel) * MAX_WAYS_DEF;
            found   = 1'b0;
            for (int w = 0; w < nways; w++) begin
                if (!found && way_valid[base + w] && way_tag[base + w] == tag) begin
                    way_stamp[base + w] = stamp_now;
                    res.was_hit = 1'b1;
                    found = 1'b1;
                end
            end
            if (!found) begin
                res.was_miss = 1'b1;
                for (int w = 0; w < nways; w++) begin
                    if (!found && !way_valid[base + w]) begin
                        way_valid[base + w] = 1'b1;
                        way_tag[base + w]   = tag;
                        way_stamp[base + w] = stamp_now;
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                victim = 0;
                oldest = way_stamp[base];
                for (int w = 0; w < nways; w++) begin
                    if (way_stamp[base + w] <= oldest) begin
                        oldest = way_stamp[base + w];
                        victim = w;
                    end
                end
                res.was_eviction = 1'b1;
                way_valid[base + victim] = 1'b1;
                way_tag[base + victim]   = tag;
                way_stamp[base + victim] = stamp_now;
            end
            hits_seen      = hits_seen + res.was_hit;
            misses_seen    = misses_seen + res.was_miss;
            evictions_seen = evictions_seen + res.was_eviction;
            if (acc.opcode == OP_MODIFY)
                hits_seen = hits_seen + 1'b1;
        end
        res.hit_count      = hits_seen;
        res.miss_count     = misses_seen;
        res.eviction_count = evictions_seen;
        return res;
    endfunction

    function automatic void plan_access(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] addr);
        plan_step_t s;
        s = '0;
        s.kind = STEP_ACCESS;
        s.acc.opcode = op;
        s.acc.address = addr;
        access_plan.push_back(s);
        total_accesses++;
    endfunction

    function automatic void plan_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        plan_step_t s;
        s = '0;
        s.kind = STEP_CONFIG;
        s.reg_index = idx;
        s.reg_value = val;
        access_plan.push_back(s);
        case (idx)
            CFG_SET_BITS:   plan_set_bits = val[2:0];
            CFG_BLOCK_BITS: plan_block_bits = val[5:0];
            CFG_WAYS_USED:  plan_ways = val[3:0];
            default: ;
        endcase
    endfunction

    function automatic void plan_mode(int sp, int rp);
        plan_step_t s;
        s = '0;
        s.kind = STEP_MODE;
        s.send_pct = sp[6:0];
        s.recv_pct = rp[6:0];
        access_plan.push_back(s);
    endfunction

    function automatic void plan_drain();
        plan_step_t s;
        s = '0;
        s.kind = STEP_DRAIN;
        access_plan.push_back(s);
    endfunction

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // driver: one transaction at a time from the plan, configuration only when idle
    always @(posedge clk or negedge rst_n)
    begin : driver
        plan_step_t             head;
        logic                   nv;
        access_t                np;
        logic                   nwe;
        logic [CFG_INDEX_W-1:0] nidx;
        logic [CFG_DATA_W-1:0]  ndata;
        if (!rst_n)
        begin
            acc_valid   <= 1'b0;
            acc_payload <= '0;
            cfg_we      <= 1'b0;
            cfg_index   <= '0;
            cfg_data    <= '0;
        end
        else
        begin
            nv    = acc_valid;
            np    = acc_payload;
            nwe   = 1'b0;
            nidx  = cfg_index;
            ndata = cfg_data;
            if (acc_valid && req.ready)
            begin
                expected_results.push_back(cache_lookup(acc_payload));
                accepted_count++;
                nv = 1'b0;
            end
            if (expected_results.size() == 0 && !nv)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nv && access_plan.size() != 0)
            begin
                head = access_plan[0];
                case (head.kind)
                    STEP_ACCESS:
                        if ($urandom_range(99) >= send_idle_pct)
                        begin
                            nv = 1'b1;
                            np = head.acc;
                            void'(access_plan.pop_front());
                        end
                    STEP_CONFIG:
                        if (quiet_cycles >= SETTLE_CYCLES)
                        begin
                            nwe   = 1'b1;
                            nidx  = head.reg_index;
                            ndata = head.reg_value;
                            case (head.reg_index)
                                CFG_SET_BITS:   cur_set_bits = head.reg_value[2:0];
                                CFG_BLOCK_BITS: cur_block_bits = head.reg_value[5:0];
                                CFG_WAYS_USED:  cur_ways = head.reg_value[3:0];
                                default: ;
                            endcase
                            void'(access_plan.pop_front());
                        end
                    STEP_DRAIN:
                        if (quiet_cycles >= SETTLE_CYCLES)
                            void'(access_plan.pop_front());
                    default:
                    begin
                        send_idle_pct = head.send_pct;
                        recv_idle_pct = head.recv_pct;
                        void'(access_plan.pop_front());
                    end
                endcase
            end
            acc_valid   <= nv;
            acc_payload <= np;
            cfg_we      <= nwe;
            cfg_index   <= nidx;
            cfg_data    <= ndata;
        end
    end

    // monitor: check each result transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        result_t got;
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (rsp.valid && res_ready)
            begin
                got = rsp.payload;
                if (expected_results.size() == 0)
                begin
                    if (err_count < REPORT_LIMIT)
                        $display("unexpected result: hit %0b miss %0b evict %0b counts %0d/%0d/%0d",
                                 got.was_hit, got.was_miss, got.was_eviction,
                                 got.hit_count, got.miss_count, got.eviction_count);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.was_hit !== want.was_hit || got.was_miss !== want.was_miss ||
                        got.was_eviction !== want.was_eviction ||
                        got.hit_count !== want.hit_count || got.miss_count !== want.miss_count ||
                        got.eviction_count !== want.eviction_count)
                    begin
                        if (err_count < REPORT_LIMIT)
                            $display("mismatch: expected %0b%0b%0b %0d/%0d/%0d got %0b%0b%0b %0d/%0d/%0d",
                                     want.was_hit, want.was_miss, want.was_eviction,
                                     want.hit_count, want.miss_count, want.eviction_count,
                                     got.was_hit, got.was_miss, got.was_eviction,
                                     got.hit_count, got.miss_count, got.eviction_count);
                        err_count++;
                    end
                end
            end
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        int                  sbv;
        int                  bbv;
        int                  wv;
        int                  sp;
        int                  rp;
        int                  sb_eff;
        int                  nways;
        int                  set_span;
        int                  r;
        logic [OPCODE_W-1:0] op;
        logic [ADDR_W-1:0]   tag_base;
        logic [ADDR_W-1:0]   tag;
        logic [ADDR_W-1:0]   set_sel;
        logic [ADDR_W-1:0]   off;
        logic [ADDR_W-1:0]   addr;

        plan_mode(0, 0);
        plan_access(OP_LOAD,    64'h0);
        plan_access(OP_LOAD,    64'h8);
        plan_access(OP_STORE,   64'hF);
        plan_access(OP_MODIFY,  64'h0);
        plan_access(OP_LOAD,    64'h100);
        plan_access(OP_LOAD,    64'hFFFF_FFFF_FFFF_FFFF);
        plan_access(OP_INVALID, 64'h0);
        plan_access(OP_INVALID, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_access(OP_LOAD,    64'h8000_0000_0000_0000);

        // walk the replacement order in one set
        plan_config(CFG_WAYS_USED, 6'd3);
        plan_access(OP_LOAD,   64'h110);
        plan_access(OP_STORE,  64'h210);
        plan_access(OP_LOAD,   64'h310);
        plan_access(OP_LOAD,   64'h110);
        plan_access(OP_LOAD,   64'h410);
        plan_access(OP_LOAD,   64'h210);
        plan_access(OP_MODIFY, 64'h110);
        plan_access(OP_LOAD,   64'h310);

        // shrink and regrow the ways: hidden lines keep their contents
        plan_config(CFG_WAYS_USED, 6'd1);
        plan_access(OP_LOAD, 64'h110);
        plan_access(OP_LOAD, 64'h210);
        plan_config(CFG_WAYS_USED, 6'd3);
        plan_access(OP_LOAD, 64'h310);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin sbv = 4;  bbv = 4;  wv = 4;  sp = 0;  rp = 0;  end
                1: begin sbv = 0;  bbv = 0;  wv = 8;  sp = 48; rp = 0;  end
                2: begin sbv = 6;  bbv = 57; wv = 2;  sp = 0;  rp = 48; end
                3: begin sbv = 63; bbv = 63; wv = 63; sp = 36; rp = 36; end
                4: begin sbv = 2;  bbv = 6;  wv = 0;  sp = 0;  rp = 0;  end
                5: begin sbv = 3;  bbv = 12; wv = 3;  sp = 48; rp = 0;  end
                6: begin sbv = 1;  bbv = 5;  wv = 8;  sp = 0;  rp = 48; end
                default: begin sbv = 5; bbv = 0; wv = 5; sp = 36; rp = 36; end
            endcase
            plan_mode(sp, rp);
            plan_config(CFG_SET_BITS, sbv[5:0]);
            plan_config(CFG_BLOCK_BITS, bbv[5:0]);
            plan_config(CFG_WAYS_USED, wv[5:0]);
            if (p == 5)
                plan_config(CFG_UNUSED, 6'($urandom));
            sb_eff   = (plan_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(plan_set_bits);
            nways    = (plan_ways == 0) ? 1 : int'(plan_ways);
            nways    = (nways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : nways;
            set_span = ((1 << sb_eff) < 3) ? (1 << sb_eff) : 3;
            tag_base = {$urandom, $urandom};
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 || $urandom_range(39) == 0)
                    plan_drain();
                case ($urandom_range(2))
                    0: op = OP_LOAD;
                    1: op = OP_STORE;
                    default: op = OP_MODIFY;
                endcase
                r = $urandom_range(99);
                if (r < 5)
                    plan_access(OP_INVALID, {$urandom, $urandom});
                else if (r < 15)
                    plan_access(op, {$urandom, $urandom});
                else
                begin
                    set_sel = $urandom_range((r < 25) ? (1 << sb_eff) - 1 : set_span - 1);
                    tag     = tag_base + $urandom_range(nways + 2);
                    off     = {$urandom, $urandom} & ((64'd1 << plan_block_bits) - 64'd1);
                    addr    = (tag << (sb_eff + plan_block_bits)) | (set_sel << plan_block_bits) | off;
                    plan_access(op, addr);
                end
            end
        end

        while (access_plan.size() != 0 || accepted_count != total_accesses ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        err_count += expected_results.size();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
